FILE: rtl/block_bitmap_allocator_unit_macros.svh
// Assertion macros of the block bitmap allocator, used by its top level.
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbm next-cycle check failed");

`endif

FILE: rtl/bbm_pkg.sv
// Types and constants of the block bitmap allocator.
`default_nettype none

package bbm_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int DEPTH      = MAX_BLOCKS / WORD_BITS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int BLK_W      = 12;
    localparam int LIM_W      = 13;
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(MAX_BLOCKS);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_OUT_OF_BLOCKS = 2'd1,
        ST_DOUBLE_FREE   = 2'd2,
        ST_OUT_OF_RANGE  = 2'd3
    } bbm_status_t;

    typedef struct packed {
        logic             action;
        logic [BLK_W-1:0] block_number;
    } bbm_req_t;

    typedef struct packed {
        logic [BLK_W-1:0] granted_block;
        bbm_status_t      status;
    } bbm_rsp_t;

    typedef struct packed {
        logic        load;
        logic        rd_start;
        logic        rd_next;
        logic        set_bit;
        logic        clr_bit;
        logic        emit;
        bbm_status_t emit_status;
    } bbm_cmd_t;

    typedef struct packed {
        logic is_free;
        logic range_err;
        logic lim_zero;
        logic found;
        logic last_word;
        logic bit_set;
    } bbm_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bbm_ctrl.sv
// Controller state machine of the block bitmap allocator.
`default_nettype none

module bbm_ctrl import bbm_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire bbm_stat_t stat,
    output bbm_cmd_t       cmd,
    output logic           busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (stat.is_free)
                    begin
                        if (stat.range_err)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_OUT_OF_RANGE;
                        end
                        else
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_FREE;
                        end
                    end
                    else if (stat.lim_zero)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OUT_OF_BLOCKS;
                    end
                    else
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.found)
                begin
                    cmd.set_bit     = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next      = S_IDLE;
                end
                else if (stat.last_word)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OUT_OF_BLOCKS;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_FREE:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
                if (stat.bit_set)
                begin
                    cmd.clr_bit     = 1'b1;
                    cmd.emit_status = ST_OK;
                end
                else
                begin
                    cmd.emit_status = ST_DOUBLE_FREE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: rtl/bbm_dpath.sv
// Datapath of the block bitmap allocator: bitmap RAM, limit register and bit search.
`default_nettype none

module bbm_dpath import bbm_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bbm_req_t         request,
    input  wire bbm_cmd_t         cmd,
    input  wire logic             cfg_wr,
    input  wire logic [LIM_W-1:0] cfg_data,
    output bbm_stat_t             stat,
    output logic                  done,
    output bbm_rsp_t              result
);

    logic [WORD_BITS-1:0] mem [0:DEPTH-1];
    logic [DEPTH-1:0]     valid_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rvalid_reg;
    logic [ADDR_W-1:0]    rd_idx_reg;
    logic [LIM_W-1:0]     lim_reg;
    logic [LIM_W-1:0]     lim_next;
    bbm_req_t             req_reg;
    bbm_rsp_t             result_reg;
    bbm_rsp_t             result_next;
    logic                 done_reg;

    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_en;
    logic [WORD_BITS-1:0] word;
    logic [LIM_W-1:0]     word_end;
    logic                 last_word;
    logic [BIT_W-1:0]     tail;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] free_vec;
    logic [BIT_W-1:0]     enc;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] req_bit;

    assign word      = rvalid_reg ? rdata_reg : '0;
    assign word_end  = (LIM_W'(rd_idx_reg) << BIT_W) + LIM_W'(WORD_BITS);
    assign last_word = (word_end >= lim_reg);
    assign tail      = lim_reg[BIT_W-1:0];
    assign lim_mask  = (last_word && (tail != '0))
                     ? ((WORD_BITS'(1) << tail) - WORD_BITS'(1)) : '1;
    assign free_vec  = ~word & lim_mask;
    assign req_bit   = WORD_BITS'(1) << req_reg.block_number[BIT_W-1:0];

    always_comb
    begin
        enc = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                enc = BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        stat.is_free   = (request.action == ACT_FREE);
        stat.range_err = ({1'b0, request.block_number} >= lim_reg);
        stat.lim_zero  = (lim_reg == '0);
        stat.found     = |free_vec;
        stat.last_word = last_word;
        stat.bit_set   = |(word & req_bit);
    end

    assign rd_en   = cmd.rd_start | cmd.rd_next;
    assign rd_addr = cmd.rd_start
                   ? ((request.action == ACT_FREE) ? request.block_number[BLK_W-1:BIT_W] : '0)
                   : rd_idx_reg + ADDR_W'(1);
    assign wr_en   = cmd.set_bit | cmd.clr_bit;
    assign wr_data = cmd.set_bit ? (word | (WORD_BITS'(1) << enc)) : (word & ~req_bit);
    assign lim_next = (cfg_data > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : cfg_data;

    always_comb
    begin
        result_next.status        = cmd.emit_status;
        result_next.granted_block = '0;
        if (cmd.emit_status == ST_OK)
        begin
            if (req_reg.action == ACT_FREE)
            begin
                result_next.granted_block = req_reg.block_number;
            end
            else
            begin
                result_next.granted_block = {rd_idx_reg, enc};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[rd_idx_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            rd_idx_reg <= rd_addr;
        end
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            lim_reg    <= LIM_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[rd_idx_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
            if (cfg_wr)
            begin
                lim_reg <= lim_next;
            end
            done_reg <= cmd.emit;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/block_bitmap_allocator_unit.sv
// Top level of the block bitmap allocator: controller, datapath and checks.
`default_nettype none

// First-fit allocator over a used/free bitmap of 4096 blocks, held in a
// 128-word RAM with one read port that yields one 32-bit word per cycle.
// A beat is accepted when start is high and busy is low, and its result
// shows for one cycle with done high; the receiver cannot stall it. An
// allocation reads bitmap words from word 0 on until one holds a free block
// below the limit or the last word is read; a free reads its block's word.
// Done is registered from the emit that ends a beat; a free out of range or
// an allocation with a limit of zero emits while the beat is accepted.
// The limit register is written through cfg_valid and cfg_ready, which is
// high only while no beat is in progress and start is low. The bitmap reads
// as all free after reset.
module block_bitmap_allocator_unit import bbm_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bbm_req_t         request,
    output logic                  done,
    output bbm_rsp_t              result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [LIM_W-1:0] cfg_data
);

`include "block_bitmap_allocator_unit_macros.svh"

    bbm_cmd_t  cmd;
    bbm_stat_t stat;
    logic      accept;

    assign cfg_ready = ~busy & ~start;
    assign accept    = start & ~busy;

    bbm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bbm_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .cfg_wr   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

    `BBM_ASSERT_NOW(a_err_zero_block, done && (result.status != ST_OK), result.granted_block == '0)
    `BBM_ASSERT_NOW(a_done_not_busy, done, !busy)
    `BBM_ASSERT_NEXT(a_range_err, accept && (request.action == ACT_FREE) && stat.range_err, done && (result.status == ST_OUT_OF_RANGE))
    `BBM_ASSERT_NEXT(a_start_work, accept && !cmd.emit, busy && !done)

endmodule

`default_nettype wire

FILE: tb/block_bitmap_allocator_unit_test.sv
// Self-checking testbench for the block bitmap allocator: request beats, limit writes, results.
module block_bitmap_allocator_unit_test;
    import bbm_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    bbm_req_t         request   = '0;
    logic             done;
    bbm_rsp_t         result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LIM_W-1:0] cfg_data  = '0;

    block_bitmap_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    bbm_req_t         request_backlog[$];
    bbm_rsp_t         expected_grants[$];
    logic [MAX_BLOCKS-1:0] block_used  = '0;
    logic [LIM_W-1:0] block_limit = LIM_RESET;
    int               burst_left  = 0;
    int               idle_left   = 0;
    int               requests_accepted = 0;
    int               allocs_accepted   = 0;
    int               frees_accepted    = 0;
    int               results_seen      = 0;
    int               limit_writes      = 0;
    int               mismatch_count    = 0;
    int               outcome_tally[4]  = '{0, 0, 0, 0};

    function automatic bbm_rsp_t apply_request(input bbm_req_t req);
        bbm_rsp_t rsp;
        int       span;
        span = (block_limit > LIM_RESET) ? MAX_BLOCKS : int'(block_limit);
        rsp.granted_block = '0;
        if (req.action == ACT_ALLOC) begin
            rsp.status = ST_OUT_OF_BLOCKS;
            for (int b = 0; b < span; b++) begin
                if (!block_used[b]) begin
                    block_used[b]     = 1'b1;
                    rsp.granted_block = BLK_W'(b);
                    rsp.status        = ST_OK;
                    break;
                end
            end
        end else if (int'(req.block_number) >= span) begin
            rsp.status = ST_OUT_OF_RANGE;
        end else if (!block_used[req.block_number]) begin
            rsp.status = ST_DOUBLE_FREE;
        end else begin
            block_used[req.block_number] = 1'b0;
            rsp.granted_block = req.block_number;
            rsp.status        = ST_OK;
        end
        return rsp;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n) begin : request_driver
        logic     hold_start;
        bbm_req_t next_req;
        bbm_rsp_t outcome;
        if (!rst_n) begin
            start   <= 1'b0;
            request <= '0;
        end else begin
            if (cfg_valid && cfg_ready)
                block_limit = cfg_data;
            hold_start = start && busy;
            next_req   = request;
            if (start && !busy) begin
                outcome = apply_request(request);
                expected_grants.push_back(outcome);
                outcome_tally[int'(outcome.status)]++;
                requests_accepted++;
                if (request.action == ACT_ALLOC)
                    allocs_accepted++;
                else
                    frees_accepted++;
            end
            if (!hold_start) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (request_backlog.size() != 0) begin
                    next_req   = request_backlog.pop_front();
                    hold_start = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            start   <= hold_start;
            request <= next_req;
        end
    end

    always @(posedge clk) begin : result_checker
        bbm_rsp_t want;
        if (rst_n && done) begin
            results_seen++;
            if (expected_grants.size() == 0) begin
                flag_mismatch($sformatf("result block %0d status %0d with nothing outstanding",
                                        result.granted_block, result.status));
            end else begin
                want = expected_grants.pop_front();
                if (result.granted_block !== want.granted_block)
                    flag_mismatch($sformatf("granted_block expected %0d, got %0d",
                                            want.granted_block, result.granted_block));
                if (result.status !== want.status)
                    flag_mismatch($sformatf("status expected %0d, got %0d",
                                            want.status, result.status));
            end
        end
    end

    task automatic wait_until_drained();
        while (request_backlog.size() != 0 || start || expected_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        wait_until_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    task automatic queue_request(input logic action, input int blk);
        bbm_req_t req;
        req.action       = action;
        req.block_number = BLK_W'(blk);
        request_backlog.push_back(req);
    endtask

    task automatic run_phase(input logic [LIM_W-1:0] limit, input int count,
                             input int alloc_pct);
        int span;
        int allocs;
        int hot_hi;
        int pick;
        write_limit(limit);
        span   = (limit > LIM_RESET) ? MAX_BLOCKS : int'(limit);
        allocs = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                queue_request(ACT_ALLOC, $urandom_range(0, 4095));
                allocs++;
            end else begin
                pick   = $urandom_range(0, 99);
                hot_hi = (span < allocs + 8) ? span : allocs + 8;
                if (pick < 65 && hot_hi > 0)
                    queue_request(ACT_FREE, $urandom_range(0, hot_hi - 1));
                else if (pick < 80)
                    queue_request(ACT_FREE, span - 1 + int'($urandom_range(0, 2)));
                else
                    queue_request(ACT_FREE, $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limit, first-fit reuse and double free.
        queue_request(ACT_ALLOC, 4095);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_ALLOC, 2048);
        queue_request(ACT_FREE, 4095);

        // No managed blocks at all.
        write_limit(LIM_W'(0));
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_FREE, 4095);

        // Running out of blocks under a small limit.
        write_limit(LIM_W'(3));
        queue_request(ACT_ALLOC, 1);
        queue_request(ACT_ALLOC, 2);
        queue_request(ACT_ALLOC, 3);
        queue_request(ACT_FREE, 3);

        // Lowered limit hides a used block until the limit is raised.
        write_limit(LIM_W'(2));
        queue_request(ACT_FREE, 2);
        queue_request(ACT_ALLOC, 0);

        // Limit above the bitmap size saturates.
        write_limit(LIM_W'(8191));
        queue_request(ACT_FREE, 2);
        queue_request(ACT_FREE, 4095);
        queue_request(ACT_ALLOC, 4095);
        queue_request(ACT_FREE, 2048);

        write_limit(LIM_W'(1));
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 1);

        run_phase(LIM_W'(37), 150, 60);
        run_phase(LIM_W'(1), 40, 50);
        run_phase(LIM_RESET, 200, 70);
        run_phase(LIM_W'(100), 150, 55);
        run_phase(LIM_W'(8191), 150, 65);
        run_phase(LIM_W'(0), 20, 50);
        run_phase(LIM_W'(64), 150, 60);
        for (int p = 0; p < 3; p++)
            run_phase(LIM_W'($urandom_range(1, 300)), 50, 60);

        wait_until_drained();
        repeat (140) @(posedge clk);

        $display("Checked %0d results for %0d requests (%0d allocations, %0d frees) over %0d limit writes.",
                 results_seen, requests_accepted, allocs_accepted, frees_accepted, limit_writes);
        $display("Outcomes: %0d ok, %0d out of blocks, %0d double frees, %0d out of range; %0d mismatches.",
                 outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3],
                 mismatch_count);
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10000000;
        $display("Timeout with %0d results still outstanding.", expected_grants.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
